>>> rtl/core/rsb_pkg.sv
// Shared types for the run-length sprite blitter.
package rsb_pkg;

	typedef struct packed {
		logic [7:0] origin_x;
		logic [7:0] origin_y;
		logic [8:0] box_width;
	} cfg_t;

	typedef struct packed {
		logic [7:0] col;
		logic [8:0] row;
	} pos_t;

	typedef struct packed {
		logic [15:0] address;
		logic        in_canvas;
		pos_t        next_pos;
	} pix_t;

	localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
	localparam logic [1:0] REG_BOX_WIDTH = 2'd2;

	localparam logic [8:0] ROW_MAX = 9'd511;
	localparam logic [7:0] COL_MAX = 8'd255;

endpackage

>>> rtl/core/rsb_pixel_unit.sv
// Address, clip and position-advance unit shared by every pixel of a run.
module rsb_pixel_unit #(
	parameter int CANVAS_WIDTH  = 256,
	parameter int CANVAS_HEIGHT = 256
) (
	input  rsb_pkg::cfg_t cfg,
	input  rsb_pkg::pos_t pos,
	output rsb_pkg::pix_t pix
);
	import rsb_pkg::*;

	localparam logic [8:0] CW = 9'(CANVAS_WIDTH);
	localparam logic [8:0] CH = 9'(CANVAS_HEIGHT);

	logic [8:0]  cx;
	logic [9:0]  cy;
	logic        in_canvas;
	logic [16:0] row_base;
	logic [16:0] addr_full;
	logic [8:0]  wrap_at;
	logic [8:0]  col_inc;
	logic        wrap;

	assign cx = {1'b0, cfg.origin_x} + {1'b0, pos.col};
	assign cy = {2'b00, cfg.origin_y} + {1'b0, pos.row};
	assign in_canvas = (cx < CW) && (cy < {1'b0, CH});

	// in_canvas implies cy < CANVAS_HEIGHT, so the low byte of cy is exact for a height of at most 256
	assign row_base  = {9'd0, cy[7:0]} * {8'd0, CW};
	assign addr_full = row_base + {9'd0, cx[7:0]};

	assign wrap_at = (cfg.box_width == 9'd0) ? 9'd1 : cfg.box_width;
	assign col_inc = {1'b0, pos.col} + 9'd1;
	assign wrap    = (pos.col == COL_MAX) || (col_inc >= wrap_at);

	always_comb begin
		pix.address   = in_canvas ? addr_full[15:0] : 16'd0;
		pix.in_canvas = in_canvas;
		if (wrap) begin
			pix.next_pos.col = 8'd0;
			pix.next_pos.row = (pos.row == ROW_MAX) ? pos.row : pos.row + 9'd1;
		end else begin
			pix.next_pos.col = col_inc[7:0];
			pix.next_pos.row = pos.row;
		end
	end

endmodule

>>> rtl/core/rle_sprite_blit_unit.sv
// Top level: run sequencer, configuration registers and output register.
// Each colour run of n pixels (n clamped to MAX_RUN) is accepted in a transfer, then expanded
// into one framebuffer write per cycle while the output register is not stalled, set by the
// single shared address and clip unit that the run sequencer steps through the run; a start
// item or an empty run is consumed by its transfer alone. in_ready is low while a run is being
// expanded, and a stalled output register holds the sequencer. The pixel position carries
// across runs until a start item returns it to the box's top-left.
module rle_sprite_blit_unit #(
	parameter int CANVAS_WIDTH  = 256,
	parameter int CANVAS_HEIGHT = 256,
	parameter int MAX_RUN       = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [15:0] run_color,
	input  logic [6:0]  run_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_address,
	output logic [15:0] pixel_color,
	output logic        write_enable,
	output logic        last
);
	import rsb_pkg::*;

	localparam logic [6:0] RUN_CAP = 7'(MAX_RUN);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t      state_q;
	cfg_t        cfg_q;
	pos_t        pos_q;
	pix_t        pix;
	logic [6:0]  left_q;
	logic [15:0] color_q;
	logic        out_valid_q;
	logic        in_xfer;
	logic        load;
	logic [6:0]  len_c;

	rsb_pixel_unit #(
		.CANVAS_WIDTH (CANVAS_WIDTH),
		.CANVAS_HEIGHT(CANVAS_HEIGHT)
	) u_pixel (
		.cfg(cfg_q),
		.pos(pos_q),
		.pix(pix)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign load     = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign len_c    = (run_length > RUN_CAP) ? RUN_CAP : run_length;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= 8'd0;
			cfg_q.origin_y  <= 8'd0;
			cfg_q.box_width <= 9'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data[7:0];
				REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data[7:0];
				REG_BOX_WIDTH: cfg_q.box_width <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			left_q      <= 7'd0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (!action) begin
							pos_q <= '0;
						end else if (len_c != 7'd0) begin
							left_q  <= len_c;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (load) begin
						pos_q  <= pix.next_pos;
						left_q <= left_q - 7'd1;
						if (left_q == 7'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && action) begin
			color_q <= run_color;
		end
		if (load) begin
			pixel_address <= pix.address;
			pixel_color   <= color_q;
			write_enable  <= pix.in_canvas;
			last          <= (left_q == 7'd1);
		end
	end

	// start item returns the position to the box corner
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !action |=> pos_q.col == 8'd0 && pos_q.row == 9'd0)
		else $error("start transfer did not clear position");

	// a run in progress always has pixels left
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> left_q != 7'd0)
		else $error("run state with no pixels left");

	// row counter holds once saturated, until a start item
	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.row == ROW_MAX && !(in_xfer && !action) |=> pos_q.row == ROW_MAX)
		else $error("row counter left saturation");

	// a non-empty run transfer starts the sequencer
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && action && len_c != 7'd0 |=> state_q == ST_RUN && !in_ready)
		else $error("run transfer did not start sequencer");

	// clipped pixels carry a zero address
	a_clip_addr: assert property (@(posedge clk) disable iff (!arst_n)
		load && !pix.in_canvas |=> pixel_address == 16'd0)
		else $error("clipped pixel with nonzero address");

endmodule
